// ===== rtl/swtl_pkg.sv =====
// Shared types and constants for the sorted word table lookup block.
package swtl_pkg;

    // Table geometry
    localparam int TABLE_WORDS    = 4096;
    localparam int MAX_WORD_CHARS = 32;
    localparam int IDX_W          = $clog2(TABLE_WORDS);       // entry index
    localparam int CNT_W          = $clog2(TABLE_WORDS + 1);   // entry count
    localparam int CHR_W          = $clog2(MAX_WORD_CHARS);    // char position
    localparam int LEN_W          = $clog2(MAX_WORD_CHARS + 1); // word length
    localparam int ADDR_W         = IDX_W + CHR_W;             // word store address
    localparam int MATCH_W        = 12;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Case folding bounds
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'd32;

    // Search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP
    } state_t;

    // Fold a lowercase letter to upper case
    function automatic logic [7:0] fold_upper(input logic [7:0] ch);
        logic [7:0] res;
        res = ch;
        if (ch >= LOWER_A && ch <= LOWER_Z)
        begin
            res = ch - CASE_DELTA;
        end
        return res;
    endfunction

endpackage

// ===== rtl/sorted_word_table_lookup_core.sv =====
// Whitelist word table with a byte-serial binary search sequencer.
// A load character never starts a search and busy stays low. A query's last character
//   starts a search. Each probe reads the middle entry's first byte, then bytes compare in
//   turn until they differ or the shorter word runs out; a probe on an empty window misses.
//   done rises the cycle after the search ends, as busy drops. One search at a time, busy
//   holds off all beats; reset clears control registers only, not the tables or result.
module sorted_word_table_lookup_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic [7:0]                   character,
    input  logic                         word_end,
    output logic                         done,
    output logic                         found,
    output logic [swtl_pkg::MATCH_W-1:0] match_index
);

    // Sequencer and counters
    swtl_pkg::state_t                 state_reg, state_next;
    logic [swtl_pkg::CNT_W-1:0]       lo_reg, lo_next;
    logic [swtl_pkg::CNT_W-1:0]       hi_reg, hi_next;
    logic [swtl_pkg::IDX_W-1:0]       mid_reg, mid_next;
    logic [swtl_pkg::LEN_W-1:0]       pos_reg, pos_next;
    logic [swtl_pkg::LEN_W-1:0]       qlen_reg, qlen_next;
    logic [swtl_pkg::LEN_W-1:0]       load_pos_reg, load_pos_next;
    logic [swtl_pkg::CNT_W-1:0]       entries_reg, entries_next;
    logic                             done_reg, done_next;
    logic                             found_reg, found_next;
    logic [swtl_pkg::MATCH_W-1:0]     match_index_reg, match_index_next;

    // Memories
    logic [7:0]                  word_mem [swtl_pkg::TABLE_WORDS*swtl_pkg::MAX_WORD_CHARS];
    logic [swtl_pkg::LEN_W-1:0]  len_mem  [swtl_pkg::TABLE_WORDS];
    logic [7:0]                  qbuf_reg [swtl_pkg::MAX_WORD_CHARS];
    logic [7:0]                  word_rd_reg;
    logic [7:0]                  q_rd_reg;
    logic [swtl_pkg::LEN_W-1:0]  len_rd_reg;

    logic                             accept;
    logic                             load_ok;
    logic                             load_store;
    logic                             query_store;
    logic [swtl_pkg::CNT_W-1:0]       mid_full;
    logic [swtl_pkg::IDX_W-1:0]       rd_entry;
    logic [swtl_pkg::LEN_W-1:0]       pos_inc;
    logic [swtl_pkg::CHR_W-1:0]       rd_pos;
    logic [swtl_pkg::LEN_W-1:0]       cmp_len;
    logic                             search_open;
    logic                             at_end;
    logic                             byte_ne;
    logic                             byte_lt;
    logic                             len_eq;
    logic                             len_lt;

    // Length of a word closed this beat, counting its final character if kept
    function automatic logic [swtl_pkg::LEN_W-1:0] load_pos_next_len(
        input logic                        stored,
        input logic [swtl_pkg::LEN_W-1:0]  pos
    );
        logic [swtl_pkg::LEN_W-1:0] res;
        res = stored ? pos + swtl_pkg::LEN_W'(1) : pos;
        return res;
    endfunction

    assign accept      = start && !busy;
    assign load_ok     = entries_reg < swtl_pkg::CNT_W'(swtl_pkg::TABLE_WORDS);
    assign load_store  = accept && kind == swtl_pkg::KIND_LOAD && load_ok
                         && load_pos_reg < swtl_pkg::LEN_W'(swtl_pkg::MAX_WORD_CHARS);
    assign query_store = accept && kind == swtl_pkg::KIND_QUERY
                         && qlen_reg < swtl_pkg::LEN_W'(swtl_pkg::MAX_WORD_CHARS);

    // Midpoint of the current window
    assign search_open = lo_reg < hi_reg;
    assign mid_full    = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Byte compare unit
    assign cmp_len = (qlen_reg < len_rd_reg) ? qlen_reg : len_rd_reg;
    assign at_end  = pos_reg == cmp_len;
    assign byte_ne = q_rd_reg != word_rd_reg;
    assign byte_lt = q_rd_reg < word_rd_reg;
    assign len_eq  = qlen_reg == len_rd_reg;
    assign len_lt  = qlen_reg < len_rd_reg;

    // Read addresses: first byte on a probe, next byte while comparing
    assign pos_inc  = pos_reg + swtl_pkg::LEN_W'(1);
    assign rd_entry = (state_reg == swtl_pkg::ST_PROBE) ? mid_full[swtl_pkg::IDX_W-1:0]
                                                        : mid_reg;
    assign rd_pos   = (state_reg == swtl_pkg::ST_PROBE) ? '0
                                                        : pos_inc[swtl_pkg::CHR_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swtl_pkg::ST_IDLE:
            begin
                if (accept && kind == swtl_pkg::KIND_QUERY && word_end)
                begin
                    state_next = swtl_pkg::ST_PROBE;
                end
            end
            swtl_pkg::ST_PROBE:
            begin
                if (search_open)
                begin
                    state_next = swtl_pkg::ST_CMP;
                end
                else
                begin
                    state_next = swtl_pkg::ST_IDLE;
                end
            end
            swtl_pkg::ST_CMP:
            begin
                if (at_end && len_eq)
                begin
                    state_next = swtl_pkg::ST_IDLE;
                end
                else if (at_end || byte_ne)
                begin
                    state_next = swtl_pkg::ST_PROBE;
                end
            end
            default:
            begin
                state_next = swtl_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        pos_next         = pos_reg;
        qlen_next        = qlen_reg;
        load_pos_next    = load_pos_reg;
        entries_next     = entries_reg;
        done_next        = 1'b0;
        found_next       = found_reg;
        match_index_next = match_index_reg;
        unique case (state_reg)
            swtl_pkg::ST_IDLE:
            begin
                if (accept && kind == swtl_pkg::KIND_LOAD && load_ok)
                begin
                    if (load_store)
                    begin
                        load_pos_next = load_pos_reg + swtl_pkg::LEN_W'(1);
                    end
                    if (word_end)
                    begin
                        entries_next  = entries_reg + swtl_pkg::CNT_W'(1);
                        load_pos_next = '0;
                    end
                end
                if (query_store)
                begin
                    qlen_next = qlen_reg + swtl_pkg::LEN_W'(1);
                end
                if (accept && kind == swtl_pkg::KIND_QUERY && word_end)
                begin
                    lo_next = '0;
                    hi_next = entries_reg;
                end
            end
            swtl_pkg::ST_PROBE:
            begin
                mid_next = mid_full[swtl_pkg::IDX_W-1:0];
                pos_next = '0;
                if (!search_open)
                begin
                    done_next        = 1'b1;
                    found_next       = 1'b0;
                    match_index_next = '0;
                    qlen_next        = '0;
                end
            end
            swtl_pkg::ST_CMP:
            begin
                if (at_end && len_eq)
                begin
                    done_next        = 1'b1;
                    found_next       = 1'b1;
                    match_index_next = swtl_pkg::MATCH_W'(mid_reg);
                    qlen_next        = '0;
                end
                else if ((at_end && len_lt) || (!at_end && byte_ne && byte_lt))
                begin
                    hi_next = swtl_pkg::CNT_W'(mid_reg);
                end
                else if (at_end || byte_ne)
                begin
                    lo_next = swtl_pkg::CNT_W'(mid_reg) + swtl_pkg::CNT_W'(1);
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= swtl_pkg::ST_IDLE;
            lo_reg       <= '0;
            hi_reg       <= '0;
            pos_reg      <= '0;
            qlen_reg     <= '0;
            load_pos_reg <= '0;
            entries_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            pos_reg      <= pos_next;
            qlen_reg     <= qlen_next;
            load_pos_reg <= load_pos_next;
            entries_reg  <= entries_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mid_reg         <= mid_next;
        found_reg       <= found_next;
        match_index_reg <= match_index_next;
    end

    // Word store and length table: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (load_store)
        begin
            word_mem[{entries_reg[swtl_pkg::IDX_W-1:0],
                      load_pos_reg[swtl_pkg::CHR_W-1:0]}] <= swtl_pkg::fold_upper(character);
        end
        if (accept && kind == swtl_pkg::KIND_LOAD && load_ok && word_end)
        begin
            len_mem[entries_reg[swtl_pkg::IDX_W-1:0]] <= load_pos_next_len(load_store,
                                                                          load_pos_reg);
        end
        word_rd_reg <= word_mem[{rd_entry, rd_pos}];
        len_rd_reg  <= len_mem[rd_entry];
    end

    // Query buffer
    always_ff @(posedge clk)
    begin
        if (query_store)
        begin
            qbuf_reg[qlen_reg[swtl_pkg::CHR_W-1:0]] <= character;
        end
        q_rd_reg <= qbuf_reg[rd_pos];
    end

    assign busy        = state_reg != swtl_pkg::ST_IDLE;
    assign done        = done_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;

endmodule

// ===== rtl/swtl_chk.sv =====
// Port-level checker for the sorted word table lookup block, with its bind.
module swtl_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         kind,
    input logic [7:0]                   character,
    input logic                         word_end,
    input logic                         done,
    input logic                         found,
    input logic [swtl_pkg::MATCH_W-1:0] match_index
);

    // A result beat only ends a search
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a search in progress");

    // One result beat per search
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // A miss reports index zero
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> match_index == '0)
        else $error("nonzero index on a miss");

    // A query's last character starts a search
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == swtl_pkg::KIND_QUERY && word_end) |=> busy)
        else $error("query end did not start a search");

    // Load beats never start a search or give a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == swtl_pkg::KIND_LOAD) |=> (!busy && !done))
        else $error("load beat caused search activity");

endmodule

bind sorted_word_table_lookup_core swtl_chk u_swtl_chk (.*);
